// ----- rtl/core/b2da_pkg.sv -----
`timescale 1ns / 1ps

package b2da_pkg;

  localparam int ValueWidth = 16;
  localparam int DigitsMax  = 5;
  localparam int BcdWidth   = 4 * DigitsMax;
  localparam int CntWidth   = 3;
  localparam int CharWidth  = 6;

  localparam logic [CharWidth-1:0] AsciiZero = 6'd48;
  localparam logic [CntWidth-1:0]  CountMin  = 3'd1;
  localparam logic [CntWidth-1:0]  CountMax  = 3'd5;

  // One word moving down the conversion chain
  typedef struct packed {
    logic                  vld;
    logic [BcdWidth-1:0]   bcd;
    logic [ValueWidth-1:0] bin;
    logic [CntWidth-1:0]   cnt;
  } word_t;

  // Clamp the programmed digit count into 1..5
  function automatic logic [CntWidth-1:0] eff_count(input logic [CntWidth-1:0] raw);
    logic [CntWidth-1:0] n;
    n = raw;
    if (n < CountMin) begin
      n = CountMin;
    end
    if (n > CountMax) begin
      n = CountMax;
    end
    return n;
  endfunction

endpackage

// ----- rtl/core/binary_to_decimal_ascii.sv -----
`timescale 1ns / 1ps

// Converts a 16-bit unsigned value to ASCII decimal digits, most significant first,
// one digit per cycle on strobe, with last_digit on the final one. digit_count
// (1..5, reset 5; 0 acts as 1, 6 and 7 as 5) sets how many low digits are sent.
// A value is taken when start is high and busy low. It passes through 16 shift-add-3
// cells and then the output register. After each accept, busy holds off further values
// only until the digit runs cannot overlap (not at all for an effective count of one),
// so a new value can enter while earlier ones are still in the cells; the output sends
// one digit per cycle. Results cannot be held off; the receiver must take every strobe.
// cfg_ready is always high.
module binary_to_decimal_ascii (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [b2da_pkg::ValueWidth-1:0] value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [b2da_pkg::CntWidth-1:0]   cfg_data,
  output logic                            strobe,
  output logic [b2da_pkg::CharWidth-1:0]  digit_char,
  output logic                            last_digit
);
  import b2da_pkg::*;

  logic [CntWidth-1:0] digit_count;
  logic [CntWidth-1:0] eff;
  logic [CntWidth-1:0] gap;
  logic                acc;
  word_t               chain [0:ValueWidth];

  assign cfg_ready = 1'b1;
  assign eff       = eff_count(digit_count);
  assign acc       = start && !busy;
  assign busy      = (gap != '0);

  // config register and input spacing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= CountMax;
      gap         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        digit_count <= cfg_data;
      end
      if (acc) begin
        gap <= eff - CountMin;
      end else if (gap != '0) begin
        gap <= gap - CountMin;
      end
    end
  end

  // chain head
  always_comb begin
    chain[0].vld = acc;
    chain[0].bcd = '0;
    chain[0].bin = value;
    chain[0].cnt = eff;
  end

  // one cell per input bit
  for (genvar g = 0; g < ValueWidth; g++) begin : g_cell
    b2da_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[g]),
      .dout (chain[g+1])
    );
  end

  b2da_serializer u_ser (
    .clk        (clk),
    .rst        (rst),
    .din        (chain[ValueWidth]),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

endmodule

// ----- rtl/core/b2da_cell.sv -----
`timescale 1ns / 1ps

// One shift-add-3 step: correct each BCD digit, then shift in the next binary bit.
module b2da_cell (
  input  logic            clk,
  input  logic            rst,
  input  b2da_pkg::word_t din,
  output b2da_pkg::word_t dout
);
  import b2da_pkg::*;

  logic [BcdWidth-1:0] adj;
  word_t               dout_next;

  // add 3 to any digit of 5 or more before doubling
  always_comb begin
    adj = din.bcd;
    for (int i = 0; i < DigitsMax; i++) begin
      if (adj[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = adj[4*i +: 4] + 4'd3;
      end
    end
    dout_next.vld = din.vld;
    dout_next.bcd = {adj[BcdWidth-2:0], din.bin[ValueWidth-1]};
    dout_next.bin = {din.bin[ValueWidth-2:0], 1'b0};
    dout_next.cnt = din.cnt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else begin
      dout.vld <= dout_next.vld;
    end
    dout.bcd <= dout_next.bcd;
    dout.bin <= dout_next.bin;
    dout.cnt <= dout_next.cnt;
  end

endmodule

// ----- rtl/core/b2da_serializer.sv -----
`timescale 1ns / 1ps

// Takes a finished BCD word and sends its low cnt digits, most significant first.
module b2da_serializer (
  input  logic                           clk,
  input  logic                           rst,
  input  b2da_pkg::word_t                din,
  output logic                           strobe,
  output logic [b2da_pkg::CharWidth-1:0] digit_char,
  output logic                           last_digit
);
  import b2da_pkg::*;

  logic [BcdWidth-1:0]     aligned;
  logic [BcdWidth-5:0]     sh;
  logic [CntWidth-1:0]     rem;
  logic [CntWidth-1:0]     skip;

  // move the first digit to send into the top nibble
  always_comb begin
    skip    = CountMax - din.cnt;
    aligned = din.bcd << {skip, 2'b00};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      rem    <= '0;
    end else if (din.vld) begin
      strobe     <= 1'b1;
      digit_char <= AsciiZero + {2'b00, aligned[BcdWidth-1 -: 4]};
      last_digit <= (din.cnt == CountMin);
      sh         <= aligned[BcdWidth-5:0];
      rem        <= din.cnt - CountMin;
    end else if (rem != '0) begin
      strobe     <= 1'b1;
      digit_char <= AsciiZero + {2'b00, sh[BcdWidth-5 -: 4]};
      last_digit <= (rem == CountMin);
      sh         <= {sh[BcdWidth-9:0], 4'b0000};
      rem        <= rem - CountMin;
    end else begin
      strobe <= 1'b0;
    end
  end

  // a new word never lands while a run is still going out
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    din.vld |-> (rem == '0))
    else $error("word arrived during a digit run");

  // a run continues until its last digit
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last_digit) |=> strobe)
    else $error("digit run broke off before last digit");

  // pending digits only while a run is active
  a_rem_strobe: assert property (@(posedge clk) disable iff (rst)
    (rem != '0) |-> (strobe && !last_digit))
    else $error("pending digits without an active run");

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import b2da_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int DrainCycles = 40;

  // One expected output word: an ASCII digit and its end-of-run flag
  typedef struct packed {
    logic [CharWidth-1:0] ch;
    logic                 last;
  } digit_t;

  // Holds the digits still owed by the block and checks each one that arrives
  class digit_board;
    digit_t              awaited[$];
    logic [CntWidth-1:0] count_reg;
    int                  mismatches;

    function new();
      count_reg  = CountMax;
      mismatches = 0;
    endfunction

    function void set_count(logic [CntWidth-1:0] raw);
      count_reg = raw;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      mismatches++;
    endtask

    // Predict the digits of one accepted value, most significant first
    task note_value(logic [ValueWidth-1:0] v);
      int unsigned n;
      int unsigned scale;
      int unsigned work;
      int unsigned d;
      digit_t      dg;
      n = count_reg;
      if (n == 0) n = 1;
      if (n > DigitsMax) n = DigitsMax;
      scale = 1;
      repeat (n - 1) scale = scale * 10;
      work = v;
      // drop leading decimal digits when fewer than five are sent
      if (n < DigitsMax) work = work % (scale * 10);
      for (int k = 0; k < n; k++) begin
        d = work / scale;
        if (d > 9) d = 9;
        work    = work - d * scale;
        dg.ch   = AsciiZero + d[CharWidth-1:0];
        dg.last = (k == n - 1);
        awaited.push_back(dg);
        scale = scale / 10;
      end
    endtask

    task check_digit(logic [CharWidth-1:0] ch, logic last);
      digit_t want;
      if (awaited.size() == 0) begin
        report($sformatf("digit %0d last %0b with none outstanding", ch, last));
        return;
      end
      want = awaited.pop_front();
      if (ch !== want.ch)
        report($sformatf("digit_char %0d, wanted %0d", ch, want.ch));
      if (last !== want.last)
        report($sformatf("last_digit %0b, wanted %0b", last, want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ValueWidth-1:0] value = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CntWidth-1:0]   cfg_data = '0;
  logic                  strobe;
  logic [CharWidth-1:0]  digit_char;
  logic                  last_digit;

  digit_board sb;
  int         idle_pct;
  int         cycles = 0;

  always #1 clk = ~clk;

  binary_to_decimal_ascii dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .value      (value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .strobe     (strobe),
    .digit_char (digit_char),
    .last_digit (last_digit)
  );

  // Every strobed word is compared at the edge that ends its cycle
  always @(posedge clk) begin
    if (!rst && strobe) sb.check_digit(digit_char, last_digit);
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  // Offer one value, sometimes after a random gap, and wait for the block to take it
  task send_value(input logic [ValueWidth-1:0] v);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
    sb.note_value(v);
  endtask

  // Stop sending and let every outstanding digit come out
  task drain();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task write_count(input logic [CntWidth-1:0] raw);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= raw;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_count(raw);
  endtask

  // Mostly full-range values, with some near the decimal boundaries
  function automatic logic [ValueWidth-1:0] pick_value();
    logic [ValueWidth-1:0] edges[12];
    edges = '{16'd0, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
              16'd9999, 16'd10000, 16'd59999, 16'd60000, 16'd65535};
    if ($urandom_range(3) == 0) return edges[$urandom_range(11)];
    return ValueWidth'($urandom_range(65535));
  endfunction

  initial begin
    int left;
    int chunk;
    sb       = new();
    idle_pct = 25;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes under every count setting, reset count first
    send_value(16'd0);
    send_value(16'd65535);
    send_value(16'd1);
    send_value(16'd9);
    send_value(16'd10);
    send_value(16'd65530);
    send_value(16'd10000);
    send_value(16'd9999);
    write_count(3'd1);
    send_value(16'd0);
    send_value(16'd65535);
    send_value(16'd7);
    write_count(3'd0);     // zero acts as one digit
    send_value(16'd65535);
    send_value(16'd12345);
    write_count(3'd2);
    send_value(16'd99);
    send_value(16'd100);
    send_value(16'd65535);
    write_count(3'd3);
    send_value(16'd999);
    send_value(16'd1000);
    send_value(16'd65432);
    write_count(3'd4);
    send_value(16'd9999);
    send_value(16'd10000);
    write_count(3'd6);     // six and seven act as five
    send_value(16'd54321);
    write_count(3'd7);
    send_value(16'd65535);
    send_value(16'd0);
    write_count(3'd5);
    send_value(16'd31415);

    // Random: three idle profiles, count reprogrammed between chunks
    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 25 : (phase == 1) ? 45 : 0;
      left = 160;
      while (left > 0) begin
        write_count(CntWidth'($urandom_range(7)));
        chunk = $urandom_range(15, 40);
        if (chunk > left) chunk = left;
        repeat (chunk) send_value(pick_value());
        left = left - chunk;
      end
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/b2da_pkg.sv
rtl/core/b2da_cell.sv
rtl/core/b2da_serializer.sv
rtl/core/binary_to_decimal_ascii.sv
tb/tb_top.sv
